[hw/rtl/itv_pkg.sv]
// ----------------------------------------------------------------------------
// itv_pkg
// Shared types and constants for the integer text validator: parse phases,
// radix codes, the finish record passed from parser to verdict stage, and
// character and register index codes.
// ----------------------------------------------------------------------------
`default_nettype none

package itv_pkg;

  // Parse phase of the current field
  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,  // skipping leading whitespace
    PH_SIGN  = 3'd1,  // sign seen
    PH_SZERO = 3'd2,  // signed zero seen
    PH_ZERO  = 3'd3,  // unsigned leading zero seen
    PH_NUM   = 3'd4,  // collecting digits
    PH_TRAIL = 3'd5   // skipping trailing whitespace
  } phase_t;

  // Number base of the digits being collected
  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_OCT = 2'd2
  } radix_t;

  // Summary of a finished field, handed to the verdict stage
  typedef struct packed {
    logic   ok;     // well formed, no overflow
    logic   neg;    // minus sign seen
    radix_t radix;
  } fin_t;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned OUT_W      = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_OCT_EN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEX_EN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BOUND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BOUND  = 3'd5;

  // Decimal digit counter: counts digits after the first, saturating
  localparam logic [4:0] DEC_CNT_MAX = 5'd19;
  localparam logic [4:0] DEC_CNT_SAT = 5'd31;

  // Character codes
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_A  = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

endpackage : itv_pkg

`default_nettype wire

[hw/rtl/itv_parser.sv]
// ----------------------------------------------------------------------------
// itv_parser
// Input register and per-byte parse state. Each accepted byte advances the
// phase, sign, accumulator and digit count; the last byte of a
// field loads a finish record for the verdict stage and clears the state.
// ----------------------------------------------------------------------------
`default_nettype none

module itv_parser #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // byte stream
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            char_byte,
  input  wire logic                  last_char,
  // configuration
  input  wire logic                  oct_en,
  input  wire logic                  hex_en,
  // finish record
  output logic                       fin_valid,
  input  wire logic                  fin_ready,
  output itv_pkg::fin_t              fin,
  output logic [VALUE_BITS-1:0]      fin_acc
);
  import itv_pkg::*;

  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned WW = VALUE_BITS + 4;

  // input register
  logic        s0_v_r;
  logic [7:0]  byte_r;
  logic        last_r;

  // parse state
  phase_t          phase_r, phase_nxt;
  logic            neg_r, neg_nxt;
  logic [VB-1:0]   acc_r, acc_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  radix_t          rdx_r, rdx_nxt;
  logic            fail_r, fail_nxt;

  // finish register
  logic            fin_v_r;
  fin_t            fin_r;
  logic [VB-1:0]   fin_acc_r;

  logic s0_fire, fin_free;

  // character classes
  logic c_ws, c_dec, c_nz, c_oct, c_hex, c_x, c_sign;
  logic [3:0] hex_d;

  // digit unit
  radix_t        dig_rdx;
  logic          dig_ok;
  logic [VB-1:0] dig_acc;
  logic [4:0]    dig_cnt;
  logic [4:0]    cnt_inc;
  logic [VB-1:0] dec_limit;
  logic [WW-1:0] dec_sum;
  logic          dec_ovf;

  // Handshake: a non-last byte always advances; a last byte needs a free
  // finish register.
  assign fin_free = !fin_v_r || fin_ready;
  assign s0_fire  = s0_v_r && (!last_r || fin_free);
  assign in_ready = !s0_v_r || s0_fire;

  // Classify the held byte
  always_comb begin
    c_ws   = (byte_r == CH_SP) || (byte_r == CH_TAB) || (byte_r == CH_CR) ||
             (byte_r == CH_LF) || (byte_r == CH_VT);
    c_dec  = (byte_r >= CH_0) && (byte_r <= CH_9);
    c_nz   = (byte_r >= CH_1) && (byte_r <= CH_9);
    c_oct  = (byte_r >= CH_0) && (byte_r <= CH_7);
    c_x    = (byte_r == CH_LX) || (byte_r == CH_UX);
    c_sign = (byte_r == CH_PLUS) || (byte_r == CH_MINUS);
    c_hex  = 1'b1;
    hex_d  = byte_r[3:0];
    if (c_dec) begin
      hex_d = byte_r[3:0];
    end else if (((byte_r >= CH_LA) && (byte_r <= CH_LF_A)) ||
                 ((byte_r >= CH_UA) && (byte_r <= CH_UF))) begin
      hex_d = 4'(byte_r[3:0] + 4'd9);
    end else begin
      c_hex = 1'b0;
    end
  end

  // Digit unit: append one digit in the active base and check overflow
  assign dig_rdx   = (phase_r == PH_ZERO) ? RX_OCT : rdx_r;
  assign cnt_inc   = (cnt_r < DEC_CNT_SAT) ? 5'(cnt_r + 5'd1) : cnt_r;
  assign dec_limit = neg_r ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
  assign dec_sum   = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) +
                     WW'(byte_r[3:0]);
  assign dec_ovf   = dec_sum > {4'b0, dec_limit};

  always_comb begin
    dig_ok  = 1'b0;
    dig_acc = acc_r;
    dig_cnt = cnt_r;
    case (dig_rdx)
      RX_DEC: begin
        dig_cnt = cnt_inc;
        dig_ok  = c_dec && (cnt_inc <= DEC_CNT_MAX) && !dec_ovf;
        dig_acc = dec_sum[VB-1:0];
      end
      RX_HEX: begin
        dig_ok  = c_hex && !(|acc_r[VB-1 -: 4]);
        dig_acc = {acc_r[VB-5:0], hex_d};
      end
      RX_OCT: begin
        dig_ok  = c_oct && !(|acc_r[VB-1 -: 3]);
        dig_acc = {acc_r[VB-4:0], byte_r[2:0]};
      end
      default: begin
        dig_ok = 1'b0;
      end
    endcase
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (!fail_r) begin
      unique case (phase_r)
        PH_LEAD: begin
          if (byte_r == CH_0)  phase_nxt = PH_ZERO;
          else if (c_sign)     phase_nxt = PH_SIGN;
          else if (c_nz)       phase_nxt = PH_NUM;
        end
        PH_SIGN: begin
          if (byte_r == CH_0)  phase_nxt = PH_SZERO;
          else if (c_nz)       phase_nxt = PH_NUM;
        end
        PH_SZERO: begin
          if (c_ws) phase_nxt = PH_TRAIL;
        end
        PH_ZERO: begin
          if (c_ws)                              phase_nxt = PH_TRAIL;
          else if ((hex_en && c_x) || oct_en)    phase_nxt = PH_NUM;
        end
        PH_NUM: begin
          if (c_ws) phase_nxt = PH_TRAIL;
        end
        PH_TRAIL: phase_nxt = PH_TRAIL;
        default:  phase_nxt = PH_LEAD;
      endcase
    end
  end

  // Next sign, accumulator, count, base and fail flag
  always_comb begin
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    rdx_nxt  = rdx_r;
    fail_nxt = fail_r;
    if (!fail_r) begin
      unique case (phase_r)
        PH_LEAD: begin
          if (c_sign) begin
            neg_nxt = (byte_r == CH_MINUS);
          end else if (c_nz) begin
            acc_nxt = VB'(byte_r[3:0]);
            rdx_nxt = RX_DEC;
          end else if (!c_ws && (byte_r != CH_0)) begin
            fail_nxt = 1'b1;
          end
        end
        PH_SIGN: begin
          if (c_nz) begin
            acc_nxt = VB'(byte_r[3:0]);
            rdx_nxt = RX_DEC;
          end else if (byte_r != CH_0) begin
            fail_nxt = 1'b1;
          end
        end
        PH_SZERO: begin
          fail_nxt = !c_ws;
        end
        PH_ZERO: begin
          if (c_ws) begin
            fail_nxt = 1'b0;
          end else if (hex_en && c_x) begin
            rdx_nxt = RX_HEX;
            acc_nxt = '0;
          end else if (oct_en) begin
            rdx_nxt  = RX_OCT;
            acc_nxt  = dig_ok ? dig_acc : '0;
            fail_nxt = !dig_ok;
          end else begin
            fail_nxt = 1'b1;
          end
        end
        PH_NUM: begin
          if (!c_ws) begin
            cnt_nxt  = dig_cnt;
            if (dig_ok) acc_nxt = dig_acc;
            fail_nxt = !dig_ok;
          end
        end
        PH_TRAIL: begin
          fail_nxt = !c_ws;
        end
        default: begin
          fail_nxt = 1'b1;
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_ready) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= char_byte;
      last_r <= last_char;
    end
  end

  // Parse state: advance on each byte, clear after the last one
  always_ff @(posedge clk) begin
    if (!rst_n || (s0_fire && last_r)) begin
      phase_r <= PH_LEAD;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      cnt_r   <= '0;
      rdx_r   <= RX_DEC;
      fail_r  <= 1'b0;
    end else if (s0_fire) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      rdx_r   <= rdx_nxt;
      fail_r  <= fail_nxt;
    end
  end

  // Finish register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (fin_free) begin
      fin_v_r <= s0_fire && last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire && last_r && fin_free) begin
      fin_r.ok    <= !fail_nxt && (phase_nxt != PH_LEAD) && (phase_nxt != PH_SIGN);
      fin_r.neg   <= neg_nxt;
      fin_r.radix <= rdx_nxt;
      fin_acc_r   <= acc_nxt;
    end
  end

  assign fin_valid = fin_v_r;
  assign fin       = fin_r;
  assign fin_acc   = fin_acc_r;

endmodule : itv_parser

`default_nettype wire

[hw/rtl/itv_verdict.sv]
// ----------------------------------------------------------------------------
// itv_verdict
// Turns a finish record into the signed result, applies the optional bounds
// and holds the verdict in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module itv_verdict #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // finish record
  input  wire logic                         fin_valid,
  output logic                              fin_ready,
  input  wire itv_pkg::fin_t                fin,
  input  wire logic [VALUE_BITS-1:0]        fin_acc,
  // bounds
  input  wire logic                         min_enable,
  input  wire logic signed [itv_pkg::OUT_W-1:0] min_bound,
  input  wire logic                         max_enable,
  input  wire logic signed [itv_pkg::OUT_W-1:0] max_bound,
  // result
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_is_valid,
  output logic signed [itv_pkg::OUT_W-1:0]  out_parsed_value
);
  import itv_pkg::*;

  logic                    out_v_r;
  logic                    ok_r;
  logic signed [OUT_W-1:0] val_r;

  logic                    out_free;
  logic signed [OUT_W-1:0] zext, value;
  logic                    pass;

  assign out_free  = !out_v_r || out_ready;
  assign fin_ready = out_free;

  // Form the signed value: decimal applies the sign, hex and octal
  // reinterpret the bit pattern as two's complement
  always_comb begin
    zext = OUT_W'(fin_acc);
    case (fin.radix)
      RX_DEC:  value = fin.neg ? OUT_W'(OUT_W'(0) - zext) : zext;
      default: value = OUT_W'($signed(fin_acc));
    endcase
    pass = fin.ok &&
           !(min_enable && (value < min_bound)) &&
           !(max_enable && (max_bound < value));
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && out_free) begin
      ok_r  <= pass;
      val_r <= pass ? value : '0;
    end
  end

  assign out_valid        = out_v_r;
  assign out_is_valid     = ok_r;
  assign out_parsed_value = val_r;

endmodule : itv_verdict

`default_nettype wire

[hw/rtl/integer_text_validator.sv]
// Path: after a field's last byte is accepted, the parse update loads its record
// into the finish register, then the verdict register presents the verdict.
// Throughput: one byte per cycle unless stalled; a waiting verdict stalls the last byte
// of the second field behind it and every byte after it; earlier bytes keep streaming.
// Reset: synchronous active-low; clears the pipeline valid flags, the parse state and
// all configuration registers to zero.
// ----------------------------------------------------------------------------
// integer_text_validator
// Parses a text field, one character per item, as a decimal, hex or octal
// integer and, after the last byte, emits one verdict with the signed value (zero on failure).
// ----------------------------------------------------------------------------
`default_nettype none

module integer_text_validator #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [itv_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [itv_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  // input characters
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [7:0]                           in_char_byte,
  input  wire logic                                 in_last_char,
  // verdicts
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_is_valid,
  output logic signed [itv_pkg::OUT_W-1:0]          out_parsed_value
);
  import itv_pkg::*;

  logic                    oct_en_r;
  logic                    hex_en_r;
  logic                    min_enable_r;
  logic signed [OUT_W-1:0] min_bound_r;
  logic                    max_enable_r;
  logic signed [OUT_W-1:0] max_bound_r;

  logic                    fin_valid, fin_ready;
  fin_t                    fin;
  logic [VALUE_BITS-1:0]   fin_acc;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_en_r      <= 1'b0;
      hex_en_r      <= 1'b0;
      min_enable_r  <= 1'b0;
      min_bound_r   <= '0;
      max_enable_r  <= 1'b0;
      max_bound_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OCT_EN:      oct_en_r      <= cfg_wdata[0];
        CFG_HEX_EN:      hex_en_r      <= cfg_wdata[0];
        CFG_MIN_ENABLE:  min_enable_r  <= cfg_wdata[0];
        CFG_MIN_BOUND:   min_bound_r   <= $signed(cfg_wdata[OUT_W-1:0]);
        CFG_MAX_ENABLE:  max_enable_r  <= cfg_wdata[0];
        CFG_MAX_BOUND:   max_bound_r   <= $signed(cfg_wdata[OUT_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  itv_parser #(
    .VALUE_BITS (VALUE_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_byte   (in_char_byte),
    .last_char   (in_last_char),
    .oct_en      (oct_en_r),
    .hex_en      (hex_en_r),
    .fin_valid   (fin_valid),
    .fin_ready   (fin_ready),
    .fin         (fin),
    .fin_acc     (fin_acc)
  );

  itv_verdict #(
    .VALUE_BITS (VALUE_BITS)
  ) u_verdict (
    .clk              (clk),
    .rst_n            (rst_n),
    .fin_valid        (fin_valid),
    .fin_ready        (fin_ready),
    .fin              (fin),
    .fin_acc          (fin_acc),
    .min_enable       (min_enable_r),
    .min_bound        (min_bound_r),
    .max_enable       (max_enable_r),
    .max_bound        (max_bound_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_valid     (out_is_valid),
    .out_parsed_value (out_parsed_value)
  );

endmodule : integer_text_validator

`default_nettype wire
